@@ rtl/tcpf_pkg.sv @@
// Shared types and constants for the two-class priority FIFO.
package tcpf_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] element_in;
        logic        want_expedited;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] element_out;
        logic        from_expedited;
        logic [7:0]  total_count;
        logic [6:0]  expedited_count;
        logic [7:0]  high_water;
    } result_t;

endpackage

@@ rtl/two_class_priority_fifo_top.sv @@
// Two-class priority FIFO: normal and expedited queues in two RAMs, with a total count and an expedited count.
// The result word is registered and appears in the cycle after the command is taken.
// Throughput: one command per cycle; busy stays low, since pointers and counts
// update at the accept edge and each RAM read or write is registered.
// Reset clears pointers, counts, the high-water mark and the enable register;
// RAM contents are not cleared. The receiver cannot stall the result strobe.
module two_class_priority_fifo_top #(
    parameter int DEPTH      = tcpf_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = tcpf_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             start,
    output logic             busy,
    input  tcpf_pkg::item_t   item,
    output logic             done,
    output tcpf_pkg::result_t result
);

    import tcpf_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int PCNT_W = $clog2(DEPTH + 1);

    logic              exp_en_reg;
    logic [PTR_W-1:0]  n_head_reg, n_tail_reg, p_head_reg, p_tail_reg;
    logic [PTR_W-1:0]  n_head_next, n_tail_next, p_head_next, p_tail_next;
    logic [CNT_W-1:0]  total_reg, total_next, peak_reg, peak_next;
    logic [PCNT_W-1:0] pri_reg, pri_next;
    logic [CNT_W-1:0]  normal_cnt;
    logic              done_reg;
    status_t           status_reg, status_next;
    logic              from_pri_reg, from_pri_next;
    logic              deq_ok_reg, deq_ok_next;

    logic              accept;
    logic              to_pri;
    logic              n_we, p_we;
    logic [DATA_WIDTH+31:0] in_ext;
    logic [DATA_WIDTH-1:0]  wdata;
    logic [DATA_WIDTH-1:0]  n_rdata, p_rdata, sel_rdata;
    logic [DATA_WIDTH+31:0] out_ext;
    logic [CNT_W+7:0]       total_ext, peak_ext;
    logic [PCNT_W+6:0]      pri_ext;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // fit the input word to the stored width
    assign in_ext = {{DATA_WIDTH{1'b0}}, item.element_in};
    assign wdata  = in_ext[DATA_WIDTH-1:0];

    assign normal_cnt = total_reg - CNT_W'(pri_reg);
    assign to_pri     = item.want_expedited && exp_en_reg;

    // decide the command against current pointers and counts
    always_comb
    begin
        n_head_next   = n_head_reg;
        n_tail_next   = n_tail_reg;
        p_head_next   = p_head_reg;
        p_tail_next   = p_tail_reg;
        total_next    = total_reg;
        pri_next      = pri_reg;
        peak_next     = peak_reg;
        status_next   = ST_OK;
        from_pri_next = 1'b0;
        deq_ok_next   = 1'b0;
        n_we          = 1'b0;
        p_we          = 1'b0;
        if (accept)
        begin
            case (item.command)
                CMD_ENQUEUE:
                begin
                    if (to_pri)
                    begin
                        if (pri_reg == PCNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            p_we        = 1'b1;
                            p_tail_next = ptr_inc(p_tail_reg);
                            pri_next    = pri_reg + PCNT_W'(1);
                            total_next  = total_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (normal_cnt >= CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            n_we        = 1'b1;
                            n_tail_next = ptr_inc(n_tail_reg);
                            total_next  = total_reg + CNT_W'(1);
                        end
                    end
                    if (total_next > peak_reg)
                    begin
                        peak_next = total_next;
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (total_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (pri_reg != '0)
                    begin
                        deq_ok_next   = 1'b1;
                        from_pri_next = 1'b1;
                        p_head_next   = ptr_inc(p_head_reg);
                        pri_next      = pri_reg - PCNT_W'(1);
                        total_next    = total_reg - CNT_W'(1);
                    end
                    else
                    begin
                        deq_ok_next = 1'b1;
                        n_head_next = ptr_inc(n_head_reg);
                        total_next  = total_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // hold the enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            exp_en_reg <= cfg_data;
        end
    end

    // advance pointers, counts and the result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_head_reg   <= '0;
            n_tail_reg   <= '0;
            p_head_reg   <= '0;
            p_tail_reg   <= '0;
            total_reg    <= '0;
            pri_reg      <= '0;
            peak_reg     <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            from_pri_reg <= 1'b0;
            deq_ok_reg   <= 1'b0;
        end
        else
        begin
            n_head_reg   <= n_head_next;
            n_tail_reg   <= n_tail_next;
            p_head_reg   <= p_head_next;
            p_tail_reg   <= p_tail_next;
            total_reg    <= total_next;
            pri_reg      <= pri_next;
            peak_reg     <= peak_next;
            done_reg     <= accept;
            status_reg   <= status_next;
            from_pri_reg <= from_pri_next;
            deq_ok_reg   <= deq_ok_next;
        end
    end

    // both stores read their head every cycle; the result picks one
    tcpf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_normal_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_tail_reg),
        .wdata (wdata),
        .raddr (n_head_reg),
        .rdata (n_rdata)
    );

    tcpf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_priority_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_tail_reg),
        .wdata (wdata),
        .raddr (p_head_reg),
        .rdata (p_rdata)
    );

    // drop the word to zero unless a dequeue succeeded
    always_comb
    begin
        if (!deq_ok_reg)
        begin
            sel_rdata = '0;
        end
        else if (from_pri_reg)
        begin
            sel_rdata = p_rdata;
        end
        else
        begin
            sel_rdata = n_rdata;
        end
    end

    assign out_ext   = {32'b0, sel_rdata};
    assign total_ext = {8'b0, total_reg};
    assign peak_ext  = {8'b0, peak_reg};
    assign pri_ext   = {7'b0, pri_reg};

    // drive the result word
    assign done                   = done_reg;
    assign result.status          = status_reg;
    assign result.element_out     = out_ext[31:0];
    assign result.from_expedited  = from_pri_reg;
    assign result.total_count     = total_ext[7:0];
    assign result.expedited_count = pri_ext[6:0];
    assign result.high_water      = peak_ext[7:0];

endmodule

@@ rtl/tcpf_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module tcpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and read; read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
